@@ hw/rtl/hrb_pkg.sv @@
`default_nettype none
package hrb_pkg;

  // function codes of an input transaction
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_BRUSH = 2'd2;

  // brush modes
  localparam logic [1:0] MODE_RAISE   = 2'd0;
  localparam logic [1:0] MODE_LOWER   = 2'd1;
  localparam logic [1:0] MODE_FLATTEN = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SIDE     = 2'd0;
  localparam logic [1:0] REG_RADIUS   = 2'd1;
  localparam logic [1:0] REG_STRENGTH = 2'd2;
  localparam logic [1:0] REG_MODE     = 2'd3;

  localparam int CFG_W = 16;
  localparam int H_ONE = 16384;

  typedef logic signed [15:0] height_t;

endpackage
`default_nettype wire

@@ hw/rtl/heightmap_radial_brush_unit.sv @@
// Write and read transactions pass through decode and the result state, with a memory read
// state between them for an on-map read. A brush visits (2r+1)^2 pixels: a pixel off the map
// or outside the radius is stepped past in the scan state, and a touched pixel goes through the
// square-root and divider units, the multiplies, division by five and a write to the single-port height memory.
// One transaction is in work at a time; the next is taken while a result waits.
// Reset (synchronous, active high) restores the registers; the height memory is not cleared.
`default_nettype none
module heightmap_radial_brush_unit import hrb_pkg::*; #(
  parameter int MAX_SIDE   = 256,
  parameter int MAX_RADIUS = 31
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic signed [9:0]  column,
  input  wire logic signed [9:0]  row,
  input  wire logic signed [15:0] write_height,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      read_height,
  output logic                    coordinate_error,
  input  wire logic               cfg_write_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int OW    = RW + 1;
  localparam int PCW   = 12;
  localparam int D2W   = 2 * RW + 1;
  localparam int SQW   = D2W + 16;
  localparam int RTW   = (SQW + 1) / 2;
  localparam int NW    = (RW > 2) ? (17 + RW) : 20;
  localparam int DVW   = (RW > 3) ? RW : 3;
  // ceil(2^21 / 5): exact division by five for operands up to 2^18
  localparam logic [18:0] RECIP5 = 19'd419431;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CT   = 4'd3;
  localparam logic [3:0] S_PIX  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_D5   = 4'd9;
  localparam logic [3:0] S_W5   = 4'd10;
  localparam logic [3:0] S_WR   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // configuration registers
  logic [8:0]  map_side;
  logic [4:0]  brush_radius;
  logic [15:0] brush_strength;
  logic [1:0]  brush_mode;

  logic [3:0]            st;
  logic [1:0]            f_func;
  logic signed [PCW-1:0] cx;
  logic signed [PCW-1:0] cy;
  height_t               wh;
  height_t               t_h;
  logic signed [OW-1:0]  dx;
  logic signed [OW-1:0]  dy;
  logic [AW-1:0]         pix_addr;
  logic [16:0]           f_q;
  logic [31:0]           sf;
  logic signed [49:0]    prod;
  logic [37:0]           q_prod;
  logic signed [20:0]    chg;
  height_t               res_h;
  logic                  res_err;

  // height memory
  logic [15:0]   mem [DEPTH];
  logic [15:0]   mem_rdata;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;

  // datapath wires
  logic [SW-1:0]         side;
  logic [RW-1:0]         r;
  logic signed [OW-1:0]  rs;
  logic signed [PCW-1:0] px;
  logic signed [PCW-1:0] py;
  logic signed [PCW-1:0] ax;
  logic signed [PCW-1:0] ay;
  logic [2*SW-1:0]       row_base;
  logic [AW-1:0]         addr_c;
  logic                  c_in_map;
  logic                  p_in_map;
  logic signed [2*OW-1:0] dx2;
  logic signed [2*OW-1:0] dy2;
  logic [D2W-1:0]        d2;
  logic [2*RW-1:0]       rr;
  logic                  p_inside;
  logic                  last_pix;
  logic signed [OW-1:0]  dx_next;
  logic signed [OW-1:0]  dy_next;
  height_t               h_cur;
  logic signed [16:0]    h_diff;
  logic signed [20:0]    p_shift;
  logic [18:0]           p_mag;
  logic [18:0]           q_in;
  logic [16:0]           q5;
  logic                  q5_rem;
  logic signed [20:0]    h_sum;
  height_t               h_new;
  logic [RTW-1:0]        f_diff;

  logic            sq_start;
  logic            sq_done;
  logic [RTW-1:0]  sq_root;
  logic            dv_start;
  logic [NW-1:0]   dv_num;
  logic [DVW-1:0]  dv_den;
  logic            dv_done;
  logic [NW-1:0]   dv_quo;

  function automatic logic on_map(logic signed [PCW-1:0] x, logic signed [PCW-1:0] y,
                                  logic [SW-1:0] sd);
    logic ok;
    ok = !x[PCW-1] && !y[PCW-1] && ($unsigned(x) < PCW'(sd)) && ($unsigned(y) < PCW'(sd));
    return ok;
  endfunction

  function automatic height_t clamp_h(logic signed [20:0] v);
    height_t o;
    if (v > 21'sd16384)       o = 16'sd16384;
    else if (v < -21'sd16384) o = -16'sd16384;
    else                      o = 16'(v);
    return o;
  endfunction

  // saturate the geometry registers
  always_comb begin
    side = (int'(map_side) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(map_side);
    r    = (int'(brush_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(brush_radius);
    rs   = $signed({1'b0, r});
  end

  // pixel geometry and address
  always_comb begin
    px       = cx + PCW'(dx);
    py       = cy + PCW'(dy);
    ax       = (st == S_PIX) ? px : cx;
    ay       = (st == S_PIX) ? py : cy;
    row_base = ay[SW-1:0] * side;
    addr_c   = AW'(row_base + (2*SW)'(ax[SW-1:0]));
    c_in_map = on_map(cx, cy, side);
    p_in_map = on_map(px, py, side);
    dx2      = dx * dx;
    dy2      = dy * dy;
    d2       = D2W'(dx2) + D2W'(dy2);
    rr       = r * r;
    p_inside = p_in_map && (d2 <= D2W'(rr));
    last_pix = (dx == rs) && (dy == rs);
    dx_next  = (dx == rs) ? -rs : dx + OW'(1);
    dy_next  = (dx == rs) ? dy + OW'(1) : dy;
  end

  // update arithmetic; division by five through a reciprocal multiply
  always_comb begin
    h_cur   = height_t'(mem_rdata);
    h_diff  = 17'(t_h) - 17'(h_cur);
    p_shift = 21'(prod >>> 29);
    p_mag   = p_shift[20] ? 19'(-p_shift) : 19'(p_shift);
    q_in    = (brush_mode == MODE_FLATTEN) ? p_mag : 19'(sf[31:16]);
    q5      = q_prod[37:21];
    q5_rem  = (q_in != 19'(q5 * 3'd5));
    h_sum   = 21'(h_cur) + chg;
    h_new   = clamp_h(h_sum);
    f_diff  = RTW'({r, 8'h00}) - sq_root;
  end

  // iterative unit control
  always_comb begin
    sq_start = (st == S_PIX) && p_inside;
    dv_start = (st == S_SQRT) && sq_done;
    dv_num   = NW'({f_diff, 8'h00});
    dv_den   = DVW'(r);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_c;
    mem_wdata = 16'(clamp_h(21'(wh)));
    case (st)
      S_DEC: begin
        if (f_func == FUNC_WRITE && c_in_map) mem_we = 1'b1;
        if (f_func == FUNC_READ && c_in_map) mem_re = 1'b1;
        if (f_func == FUNC_BRUSH && c_in_map) mem_re = 1'b1;
      end
      S_PIX: mem_re = p_inside;
      S_WR: begin
        mem_we    = 1'b1;
        mem_addr  = pix_addr;
        mem_wdata = 16'(h_new);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_addr];
  end

  hrb_sqrt #(.VW(SQW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value ({d2, 16'h0000}),
    .done  (sq_done),
    .root  (sq_root)
  );

  hrb_div #(.NW(NW), .DW(DVW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_side       <= 9'd256;
      brush_radius   <= 5'd8;
      brush_strength <= 16'd4096;
      brush_mode     <= MODE_RAISE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SIDE:     map_side       <= cfg_data[8:0];
        REG_RADIUS:   brush_radius   <= cfg_data[4:0];
        REG_STRENGTH: brush_strength <= cfg_data[15:0];
        REG_MODE:     brush_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (st == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && st != S_DONE) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            f_func <= func;
            cx     <= PCW'(column);
            cy     <= PCW'(row);
            wh     <= write_height;
            st     <= S_DEC;
          end
        end
        S_DEC: begin
          res_h   <= '0;
          res_err <= 1'b0;
          dx      <= -rs;
          dy      <= -rs;
          t_h     <= '0;
          case (f_func)
            FUNC_WRITE: begin
              res_err <= !c_in_map;
              st      <= S_DONE;
            end
            FUNC_READ: begin
              res_err <= !c_in_map;
              st      <= c_in_map ? S_RD : S_DONE;
            end
            FUNC_BRUSH: begin
              if (r == '0 || brush_mode == MODE_NONE) st <= S_DONE;
              else if (c_in_map)                      st <= S_CT;
              else                                    st <= S_PIX;
            end
            default: st <= S_DONE;
          endcase
        end
        S_RD: begin
          res_h <= height_t'(mem_rdata);
          st    <= S_DONE;
        end
        S_CT: begin
          t_h <= height_t'(mem_rdata);
          st  <= S_PIX;
        end
        S_PIX: begin
          if (p_inside) begin
            pix_addr <= addr_c;
            st       <= S_SQRT;
          end else begin
            dx <= dx_next;
            dy <= dy_next;
            if (last_pix) st <= S_DONE;
          end
        end
        S_SQRT: begin
          if (sq_done) st <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            f_q <= dv_quo[16:0];
            st  <= S_MUL1;
          end
        end
        S_MUL1: begin
          sf <= 32'(brush_strength * f_q);
          st <= S_MUL2;
        end
        S_MUL2: begin
          prod <= h_diff * $signed({1'b0, sf});
          st   <= S_D5;
        end
        S_D5: begin
          q_prod <= q_in * RECIP5;
          st     <= S_W5;
        end
        S_W5: begin
          case (brush_mode)
            MODE_RAISE: chg <= 21'(q5);
            MODE_LOWER: chg <= -21'(q5);
            default: begin
              if (p_shift[20]) chg <= -(21'(q5) + 21'(q5_rem));
              else             chg <= 21'(q5);
            end
          endcase
          st <= S_WR;
        end
        S_WR: begin
          dx <= dx_next;
          dy <= dy_next;
          st <= last_pix ? S_DONE : S_PIX;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            read_height      <= res_h;
            coordinate_error <= res_err;
            st               <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hrb_sqrt.sv @@
`default_nettype none
// Iterative integer square root, one result bit per cycle.
module hrb_sqrt import hrb_pkg::*; #(
  parameter int VW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VW-1:0]         value,
  output logic                       done,
  output logic [(VW+1)/2-1:0]        root
);
  localparam int RTW = (VW + 1) / 2;
  localparam int PW  = 2 * RTW;
  localparam int CW  = $clog2(RTW + 1);

  logic [PW-1:0]  val;
  logic [RTW+1:0] rem;
  logic [CW-1:0]  cnt;
  logic           running;
  logic [RTW+1:0] rem_sh;
  logic [RTW+1:0] trial;
  logic           geq;

  // bring in the next bit pair and try the next root bit
  always_comb begin
    rem_sh = {rem[RTW-1:0], val[PW-1 -: 2]};
    trial  = {root, 2'b01};
    geq    = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      val     <= PW'(value);
      rem     <= '0;
      root    <= '0;
      cnt     <= CW'(RTW);
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running) begin
      val  <= val << 2;
      rem  <= geq ? (rem_sh - trial) : rem_sh;
      root <= {root[RTW-2:0], geq};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hrb_div.sv @@
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module hrb_div import hrb_pkg::*; #(
  parameter int NW = 24,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_sh;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          running;
  logic [DW:0]   part;
  logic          geq;

  // shift in the next dividend bit and compare
  always_comb begin
    part = {rem, num_sh[NW-1]};
    geq  = (part >= {1'b0, den_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      num_sh  <= num;
      den_q   <= den;
      rem     <= '0;
      quo     <= '0;
      cnt     <= CW'(NW);
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running) begin
      num_sh <= num_sh << 1;
      rem    <= geq ? DW'(part - {1'b0, den_q}) : DW'(part);
      quo    <= {quo[NW-2:0], geq};
      cnt    <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hrb_checker.sv @@
`default_nettype none
// Port-level checks on the heightmap brush unit.
module hrb_port_checks import hrb_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         func,
  input wire logic signed [9:0]  column,
  input wire logic signed [9:0]  row,
  input wire logic signed [15:0] write_height,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire height_t            read_height,
  input wire logic               coordinate_error,
  input wire logic               cfg_write_en,
  input wire logic [1:0]         cfg_index,
  input wire logic [CFG_W-1:0]   cfg_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_height) && $stable(coordinate_error))
    else $error("result changed while stalled");

  // an off-map result carries no height
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && coordinate_error |-> read_height == 16'sd0)
    else $error("coordinate error with nonzero height");

  // drop ready after taking a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // come out of reset with no result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heightmap_radial_brush_unit hrb_port_checks u_hrb_port_checks (.*);
`default_nettype wire

@@ tb/hrb_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module hrb_checker import hrb_pkg::*; #(
  parameter int MAX_SIDE   = 256,
  parameter int MAX_RADIUS = 31
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         func,
  input  wire logic signed [9:0]  column,
  input  wire logic signed [9:0]  row,
  input  wire logic signed [15:0] write_height,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] read_height,
  input  wire logic               coordinate_error,
  input  wire logic               cfg_write_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output int                      errors,
  output int                      pending
);

  typedef struct {
    height_t h;
    logic    err;
  } answer_t;

  answer_t answers[$];
  height_t heights[MAX_SIDE*MAX_SIDE];
  logic [8:0]  side_reg;
  logic [4:0]  radius_reg;
  logic [15:0] strength_reg;
  logic [1:0]  mode_reg;

  function automatic int eff_side();
    return (side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg);
  endfunction

  function automatic bit on_map(int x, int y, int sd);
    return x >= 0 && y >= 0 && x < sd && y < sd;
  endfunction

  function automatic height_t clip(longint v);
    if (v > H_ONE) return height_t'(H_ONE);
    if (v < -H_ONE) return height_t'(-H_ONE);
    return height_t'(v);
  endfunction

  // integer square root, bit by bit
  function automatic int unsigned root(int unsigned v);
    int unsigned res;
    int unsigned b;
    res = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint div_floor(longint p, longint d);
    if (p >= 0) return p / d;
    return -((-p + d - 1) / d);
  endfunction

  // update every touched pixel of a brush stroke
  function automatic void stroke(int cx, int cy);
    int sd;
    int r;
    longint t;
    longint h;
    longint f;
    longint sf;
    int d2;
    int idx;
    sd = eff_side();
    r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    t = 0;
    if (r == 0 || mode_reg > MODE_FLATTEN) return;
    if (on_map(cx, cy, sd)) t = heights[cy*sd + cx];
    for (int y = cy - r; y <= cy + r; y++) begin
      for (int x = cx - r; x <= cx + r; x++) begin
        d2 = (x-cx)*(x-cx) + (y-cy)*(y-cy);
        if (on_map(x, y, sd) && d2 <= r*r) begin
          f = (longint'(256*r) - longint'(root(d2*65536))) * 256 / r;
          if (f < 0) f = 0;
          idx = y*sd + x;
          h = heights[idx];
          sf = longint'(strength_reg) * f;
          case (mode_reg)
            MODE_RAISE: h = h + sf / 327680;
            MODE_LOWER: h = h - sf / 327680;
            default:    h = h + div_floor((t - h) * sf, longint'(10) << 28);
          endcase
          heights[idx] = clip(h);
        end
      end
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    foreach (heights[i]) heights[i] = '0;
  end

  // follow config writes, predict each input transaction, check each result
  always @(posedge clk) begin
    answer_t a;
    answer_t w;
    int sd;
    int c;
    int rw;
    if (rst) begin
      side_reg <= 9'd256;
      radius_reg <= 5'd8;
      strength_reg <= 16'd4096;
      mode_reg <= MODE_RAISE;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SIDE:     side_reg <= cfg_data[8:0];
          REG_RADIUS:   radius_reg <= cfg_data[4:0];
          REG_STRENGTH: strength_reg <= cfg_data[15:0];
          default:      mode_reg <= cfg_data[1:0];
        endcase
      end
      if (in_valid && in_ready) begin
        sd = eff_side();
        c = column;
        rw = row;
        a.h = '0;
        a.err = 1'b0;
        if (func == FUNC_WRITE || func == FUNC_READ) begin
          if (!on_map(c, rw, sd)) a.err = 1'b1;
          else if (func == FUNC_WRITE) heights[rw*sd + c] = clip(write_height);
          else a.h = heights[rw*sd + c];
        end else if (func == FUNC_BRUSH) begin
          stroke(c, rw);
        end
        answers.push_back(a);
      end
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $display("mismatch at %0t: result with nothing expected", $time);
          errors++;
        end else begin
          w = answers.pop_front();
          if (read_height !== w.h) report("read_height", read_height, w.h);
          if (coordinate_error !== w.err) report("coordinate_error", coordinate_error, w.err);
        end
      end
      pending = answers.size();
    end
  end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb import hrb_pkg::*;;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int LIMIT = 3000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] func;
  logic signed [9:0] column;
  logic signed [9:0] row;
  logic signed [15:0] write_height;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] read_height;
  logic coordinate_error;
  logic cfg_write_en;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int errors;
  int pending;
  int cycles;

  // what the stimulus knows about the current setting
  int side_now;
  int radius_now;
  int mode_now;
  int burst_left;
  bit written[65536];

  heightmap_radial_brush_unit dut (
    .clk, .rst, .in_valid, .in_ready, .func, .column, .row, .write_height,
    .out_valid, .out_ready, .read_height, .coordinate_error,
    .cfg_write_en, .cfg_index, .cfg_data
  );

  hrb_checker chk (
    .clk, .rst, .in_valid, .in_ready, .func, .column, .row, .write_height,
    .out_valid, .out_ready, .read_height, .coordinate_error,
    .cfg_write_en, .cfg_index, .cfg_data, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall the result side in stretches: free running, or random holds
  int stall_mode;
  initial out_ready = 1'b0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit on_map(int x, int y);
    return x >= 0 && y >= 0 && x < side_now && y < side_now;
  endfunction

  // true when a stroke here reads only entries that hold a written height
  function automatic bit stroke_safe(int cx, int cy);
    if (radius_now == 0 || mode_now == MODE_NONE) return 1;
    if (on_map(cx, cy) && !written[cy*side_now + cx]) return 0;
    for (int y = cy - radius_now; y <= cy + radius_now; y++)
      for (int x = cx - radius_now; x <= cx + radius_now; x++)
        if (on_map(x, y) && (x-cx)*(x-cx) + (y-cy)*(y-cy) <= radius_now*radius_now
            && !written[y*side_now + x]) return 0;
    return 1;
  endfunction

  // drive one transaction, with bursts and random gaps in front
  task automatic send(logic [1:0] f, int c, int r, int h);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    column <= 10'(c);
    row <= 10'(r);
    write_height <= 16'(h);
    if (f == FUNC_WRITE && on_map(c, r) && c < 1024 && r < 1024)
      written[r*side_now + c] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the input low until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic setup(int sd, int r, int s, int m);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_SIDE;
    cfg_data <= CFG_W'(sd);
    @(posedge clk);
    cfg_index <= REG_RADIUS;
    cfg_data <= CFG_W'(r);
    @(posedge clk);
    cfg_index <= REG_STRENGTH;
    cfg_data <= CFG_W'(s);
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_data <= CFG_W'(m);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    side_now = (sd > 256) ? 256 : sd;
    radius_now = r;
    mode_now = m;
  endtask

  task automatic brush_somewhere(int span);
    int cx;
    int cy;
    for (int k = 0; k < 20; k++) begin
      cx = $urandom_range(0, span + 2*radius_now + 2) - radius_now - 1;
      cy = $urandom_range(0, span + 2*radius_now + 2) - radius_now - 1;
      if (stroke_safe(cx, cy)) begin
        send(FUNC_BRUSH, cx, cy, $urandom);
        return;
      end
    end
    send(FUNC_BRUSH, -512, -512, $urandom);
  endtask

  // fill the top-left corner, then random traffic
  task automatic phase(int n);
    int span;
    int sel;
    int c;
    int r;
    span = (side_now > 3) ? 3 : side_now;
    for (int y = 0; y < span; y++)
      for (int x = 0; x < span; x++)
        send(FUNC_WRITE, x, y, $urandom_range(0, 2*H_ONE) - H_ONE);
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) begin
        c = $urandom_range(0, span + 1) - 1;
        r = $urandom_range(0, span + 1) - 1;
      end else begin
        c = $urandom_range(0, 1023) - 512;
        r = $urandom_range(0, 1023) - 512;
      end
      if (sel < 35) begin
        send(FUNC_WRITE, c, r, $urandom);
      end else if (sel < 70) begin
        if (on_map(c, r) && !written[r*side_now + c]) send(FUNC_WRITE, c, r, $urandom);
        else send(FUNC_READ, c, r, $urandom);
      end else if (sel < 95) begin
        brush_somewhere(span);
      end else begin
        send(FUNC_NONE, c, r, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_WRITE;
    column = '0;
    row = '0;
    write_height = '0;
    cfg_write_en = 1'b0;
    cfg_index = REG_SIDE;
    cfg_data = '0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    side_now = 256;
    radius_now = 8;
    mode_now = MODE_RAISE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edges of the map, clamped writes, off-map accesses, every operation
    send(FUNC_WRITE, 0, 0, H_ONE);
    send(FUNC_WRITE, 255, 255, -H_ONE);
    send(FUNC_WRITE, 1, 0, 32767);
    send(FUNC_WRITE, 2, 0, -32768);
    send(FUNC_WRITE, -1, 0, 100);
    send(FUNC_WRITE, 0, 256, 100);
    send(FUNC_WRITE, 511, 511, 100);
    send(FUNC_READ, 0, 0, 0);
    send(FUNC_READ, 255, 255, 0);
    send(FUNC_READ, 1, 0, 0);
    send(FUNC_READ, 2, 0, 0);
    send(FUNC_READ, -512, -512, 0);
    send(FUNC_READ, 256, 0, 0);
    send(FUNC_NONE, 5, 5, -1);
    send(FUNC_BRUSH, -512, 511, 0);
    phase(12);
    // off-map centers that reach into the filled corner
    send(FUNC_BRUSH, -5, -5, 0);
    send(FUNC_BRUSH, -6, -4, 0);
    send(FUNC_READ, 0, 0, 0);
    drain();

    // lower at full strength on a small map
    setup(8, 3, 65535, MODE_LOWER);
    phase(10);
    // single pixel map, widest radius, zero strength, flatten
    setup(1, 31, 0, MODE_FLATTEN);
    phase(6);
    setup(20, 31, 40000, MODE_FLATTEN);
    phase(12);
    // oversized side saturates; radius zero and the unused mode do nothing
    setup(511, 0, 12345, MODE_NONE);
    phase(8);
    setup(256, 6, 4096, MODE_NONE);
    phase(6);
    // empty map: every access is off the map
    setup(0, 5, 4096, MODE_RAISE);
    phase(6);
    // strong raise drives heights into the clamp
    setup(12, 1, 65535, MODE_RAISE);
    phase(12);

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
